### rtl/mpcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpcs_pkg
// Shared types and constants of the mean-pivot contrast stretch block.
// ----------------------------------------------------------------------------
package mpcs_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 65536;
  localparam int unsigned LEVELS         = 256;
  localparam int unsigned LEVEL_W        = 8;
  localparam int unsigned GAIN_RESET     = 10;
  localparam int unsigned PCT_SCALE      = 100;
  localparam int unsigned LEVEL_MAX      = 255;

  // floor(n / 100) for the table build: n is biased by 100 * FLOOR_BIAS to make
  // it positive, then divided through a reciprocal multiply.
  localparam int unsigned FLOOR_BIAS  = 1311;
  localparam int unsigned RECIP       = 671089;   // ceil(2^26 / 100)
  localparam int unsigned RECIP_SHIFT = 26;
  localparam int unsigned BIASED_W    = 18;
  localparam int unsigned RECIP_W     = 20;
  localparam int unsigned PROD_W      = BIASED_W + RECIP_W;
  localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } mpcs_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_BUILD,
    ST_READ,
    ST_LUT
  } mpcs_state_e;

  typedef struct packed {
    logic               op;
    logic [LEVEL_W-1:0] pixel_in;
  } mpcs_req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] pixel_out;
    logic               is_last;
    logic               valid_res;
  } mpcs_res_t;

  typedef struct packed {
    logic               we;
    logic [LEVEL_W-1:0] addr;
    logic [LEVEL_W-1:0] data;
  } mpcs_tbl_wr_t;

endpackage
`default_nettype wire

### rtl/mean_pivot_contrast_stretch.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mean_pivot_contrast_stretch
// Contrast stretch about the image mean through a 256-entry level table.
// ----------------------------------------------------------------------------
// Load request: no result; a load may follow every cycle while the block is idle.
// Fetch while draining: pixel memory read, then table read in ST_LUT; registered strobe, idle again then.
// First fetch of an image first runs the mean divide, then the table
//   build (256 entries through a 3-deep pipeline) and then the pixel-read issue in ST_READ.
// Empty fetch: invalid result on the next cycle, no busy time; results never stall.
// Reset clears control state only; no memory entry is read before it is written.
module mean_pivot_contrast_stretch #(
  parameter int unsigned MAX_PIXELS = mpcs_pkg::MAX_PIXELS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire mpcs_pkg::mpcs_req_t           req_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [mpcs_pkg::LEVEL_W-1:0]  cfg_gain_i,
  output mpcs_pkg::mpcs_res_t                res_o,
  output logic                               res_strobe_o
);

  localparam int unsigned LW     = mpcs_pkg::LEVEL_W;
  localparam int unsigned ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned SUM_W  = CNT_W + LW;

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  mpcs_pkg::mpcs_state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rp_q, rp_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [LW-1:0]    mean_q, mean_d;
  logic             drain_q, drain_d;
  logic [LW-1:0]    gain_q;
  logic             last_pend_q, last_pend_d;
  logic             strobe_q, strobe_d;
  logic             rvalid_q, rvalid_d;
  logic             rlast_q, rlast_d;

  logic accept;
  logic store_we, store_re, tbl_re;
  logic div_start, div_done, lut_start, lut_done;
  logic [LW-1:0] div_quot;
  logic issue_fetch;
  logic fetch_last;
  mpcs_pkg::mpcs_tbl_wr_t tbl_wr;

  // Memories
  logic [LW-1:0] store_mem [MAX_PIXELS];
  logic [LW-1:0] tbl_mem   [mpcs_pkg::LEVELS];
  logic [LW-1:0] store_rd_q;
  logic [LW-1:0] tbl_rd_q;

  assign busy   = (state_q != mpcs_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Last pixel of the image when the read pointer reaches the final entry.
  assign fetch_last = (CNT_W'(rp_q + 1'b1) == count_q);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rp_d        = rp_q;
    sum_d       = sum_q;
    mean_d      = mean_q;
    drain_d     = drain_q;
    last_pend_d = last_pend_q;
    strobe_d    = 1'b0;
    rvalid_d    = rvalid_q;
    rlast_d     = rlast_q;
    store_we    = 1'b0;
    issue_fetch = 1'b0;
    tbl_re      = 1'b0;
    div_start   = 1'b0;
    lut_start   = 1'b0;

    unique case (state_q)
      mpcs_pkg::ST_IDLE: begin
        if (accept) begin
          if (req_i.op == mpcs_pkg::OP_LOAD) begin
            // dropped when full or draining
            if (!drain_q && (count_q < CNT_W'(MAX_PIXELS))) begin
              store_we = 1'b1;
              sum_d    = sum_q + SUM_W'(req_i.pixel_in);
              count_d  = count_q + 1'b1;
            end
          end else if (count_q == '0) begin
            strobe_d = 1'b1;
            rvalid_d = 1'b0;
            rlast_d  = 1'b0;
          end else if (!drain_q) begin
            div_start = 1'b1;
            state_d   = mpcs_pkg::ST_DIV;
          end else begin
            issue_fetch = 1'b1;
          end
        end
      end
      mpcs_pkg::ST_DIV: begin
        if (div_done) begin
          mean_d    = div_quot;
          lut_start = 1'b1;
          state_d   = mpcs_pkg::ST_BUILD;
        end
      end
      mpcs_pkg::ST_BUILD: begin
        if (lut_done) begin
          drain_d = 1'b1;
          rp_d    = '0;
          state_d = mpcs_pkg::ST_READ;
        end
      end
      mpcs_pkg::ST_READ: begin
        issue_fetch = 1'b1;
      end
      mpcs_pkg::ST_LUT: begin
        tbl_re   = 1'b1;
        strobe_d = 1'b1;
        rvalid_d = 1'b1;
        rlast_d  = last_pend_q;
        state_d  = mpcs_pkg::ST_IDLE;
      end
      default: begin
        state_d = mpcs_pkg::ST_IDLE;
      end
    endcase

    // Pixel memory read at the read pointer; the image ends on its last pixel.
    if (issue_fetch) begin
      last_pend_d = fetch_last;
      state_d     = mpcs_pkg::ST_LUT;
      if (fetch_last) begin
        count_d = '0;
        sum_d   = '0;
        rp_d    = '0;
        drain_d = 1'b0;
      end else begin
        rp_d = rp_q + 1'b1;
      end
    end
  end

  assign store_re = issue_fetch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpcs_pkg::ST_IDLE;
      count_q     <= '0;
      rp_q        <= '0;
      sum_q       <= '0;
      mean_q      <= '0;
      drain_q     <= 1'b0;
      gain_q      <= LW'(mpcs_pkg::GAIN_RESET);
      last_pend_q <= 1'b0;
      strobe_q    <= 1'b0;
      rvalid_q    <= 1'b0;
      rlast_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rp_q        <= rp_d;
      sum_q       <= sum_d;
      mean_q      <= mean_d;
      drain_q     <= drain_d;
      last_pend_q <= last_pend_d;
      strobe_q    <= strobe_d;
      rvalid_q    <= rvalid_d;
      rlast_q     <= rlast_d;
      if (cfg_we_i) begin
        gain_q <= cfg_gain_i;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pixel memory: written on load, read on fetch
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[count_q[ADDR_W-1:0]] <= req_i.pixel_in;
    end
    if (store_re) begin
      store_rd_q <= store_mem[rp_q[ADDR_W-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Level table: filled by the builder, read with the fetched pixel
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (tbl_wr.we) begin
      tbl_mem[tbl_wr.addr] <= tbl_wr.data;
    end
    if (tbl_re) begin
      tbl_rd_q <= tbl_mem[store_rd_q];
    end
  end

  // --------------------------------------------------------------------------
  // Mean divider and table builder
  // --------------------------------------------------------------------------
  mpcs_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sum_q),
    .count_i (count_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  mpcs_lut_gen u_lut_gen (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (lut_start),
    .mean_i  (mean_q),
    .gain_i  (gain_q),
    .wr_o    (tbl_wr),
    .done_o  (lut_done)
  );

  // Result: an empty fetch reads as zero.
  assign res_strobe_o    = strobe_q;
  assign res_o.pixel_out = rvalid_q ? tbl_rd_q : '0;
  assign res_o.is_last   = rlast_q;
  assign res_o.valid_res = rvalid_q;

endmodule
`default_nettype wire

### rtl/mpcs_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpcs_div
// Mean divider: sum / count, one quotient bit per cycle, eight bits.
// ----------------------------------------------------------------------------
module mpcs_div #(
  parameter int unsigned SUM_W = 25,
  parameter int unsigned CNT_W = 17
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [SUM_W-1:0]               sum_i,
  input  wire logic [CNT_W-1:0]               count_i,
  output logic                                done_o,
  output logic [mpcs_pkg::LEVEL_W-1:0]        quot_o
);

  localparam int unsigned BIT_W = $clog2(mpcs_pkg::LEVEL_W);

  logic [SUM_W-1:0]               rem_q, rem_d;
  logic [mpcs_pkg::LEVEL_W-1:0]   quot_q, quot_d;
  logic [BIT_W-1:0]               bit_q, bit_d;
  logic                           run_q, run_d;
  logic                           done_q, done_d;
  logic [SUM_W-1:0]               trial;

  // Mean never exceeds the top grey level, so eight quotient bits suffice.
  assign trial = SUM_W'(count_i) << bit_q;

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    bit_d  = bit_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = sum_i;
      quot_d = '0;
      bit_d  = BIT_W'(mpcs_pkg::LEVEL_W - 1);
      run_d  = 1'b1;
    end else if (run_q) begin
      if (rem_q >= trial) begin
        rem_d          = rem_q - trial;
        quot_d[bit_q]  = 1'b1;
      end
      bit_d = bit_q - 1'b1;
      if (bit_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      bit_q  <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

### rtl/mpcs_lut_gen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpcs_lut_gen
// Table builder: one entry per cycle through a pipeline of multipliers.
// ----------------------------------------------------------------------------
module mpcs_lut_gen (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [mpcs_pkg::LEVEL_W-1:0]  mean_i,
  input  wire logic [mpcs_pkg::LEVEL_W-1:0]  gain_i,
  output mpcs_pkg::mpcs_tbl_wr_t             wr_o,
  output logic                               done_o
);

  localparam int unsigned LW = mpcs_pkg::LEVEL_W;
  localparam int unsigned BW = mpcs_pkg::BIASED_W;
  localparam int unsigned PW = mpcs_pkg::PROD_W;
  localparam int unsigned QW = mpcs_pkg::QUOT_W;

  logic          run_q;
  logic [LW-1:0] v_q;
  logic          va_q, vb_q;
  logic [LW-1:0] a_addr_q, b_addr_q;
  logic signed [19:0] n_q;
  logic [PW-1:0] p_q;

  // stage A: n = 100*m + (v - m) * (100 + g)
  logic signed [9:0]  diff;
  logic signed [9:0]  slope;
  logic [14:0]        base;
  logic signed [19:0] n_d;

  assign diff  = $signed({2'b00, v_q}) - $signed({2'b00, mean_i});
  assign slope = $signed({1'b0, 9'(mpcs_pkg::PCT_SCALE) + {1'b0, gain_i}});
  assign base  = 15'(mean_i) * 15'(mpcs_pkg::PCT_SCALE);
  assign n_d   = 20'(diff * slope) + $signed({5'b0, base});

  // stage B: bias positive, multiply by reciprocal of 100
  logic signed [19:0] biased_s;
  logic [BW-1:0]      biased;
  assign biased_s = n_q + 20'(mpcs_pkg::FLOOR_BIAS * mpcs_pkg::PCT_SCALE);
  assign biased   = biased_s[BW-1:0];

  // stage C: remove bias, clamp to grey range
  logic [QW-1:0]      quot;
  logic signed [QW:0] level;
  logic [LW-1:0]      clamped;
  assign quot  = p_q[PW-1:mpcs_pkg::RECIP_SHIFT];
  assign level = $signed({1'b0, quot}) - $signed((QW+1)'(mpcs_pkg::FLOOR_BIAS));

  always_comb begin
    if (level < 0) begin
      clamped = '0;
    end else if (level > $signed((QW+1)'(mpcs_pkg::LEVEL_MAX))) begin
      clamped = LW'(mpcs_pkg::LEVEL_MAX);
    end else begin
      clamped = level[LW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      v_q   <= '0;
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
    end else begin
      va_q <= run_q;
      vb_q <= va_q;
      if (start_i) begin
        run_q <= 1'b1;
        v_q   <= '0;
      end else if (run_q) begin
        v_q <= v_q + 1'b1;
        if (v_q == LW'(mpcs_pkg::LEVELS - 1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q      <= n_d;
    a_addr_q <= v_q;
    p_q      <= PW'(biased) * PW'(mpcs_pkg::RECIP);
    b_addr_q <= a_addr_q;
  end

  assign wr_o.we   = vb_q;
  assign wr_o.addr = b_addr_q;
  assign wr_o.data = clamped;
  assign done_o    = vb_q && (b_addr_q == LW'(mpcs_pkg::LEVELS - 1));

endmodule
`default_nettype wire

### rtl/mpcs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpcs_checker
// Port-level checks of the contrast stretch block, bound to the top level.
// ----------------------------------------------------------------------------
module mpcs_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 start,
  input wire logic                 busy,
  input wire mpcs_pkg::mpcs_req_t  req_i,
  input wire mpcs_pkg::mpcs_res_t  res_o,
  input wire logic                 res_strobe_o
);

  // An empty fetch carries no pixel and no end mark.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && !res_o.valid_res) |-> (res_o.pixel_out == '0) && !res_o.is_last)
    else $error("empty result carries data");

  // A load request never produces a result.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.op == mpcs_pkg::OP_LOAD)) |=> !res_strobe_o)
    else $error("result after load request");

  // A fetch request either answers at once or holds the block busy.
  a_fetch_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.op == mpcs_pkg::OP_FETCH)) |=> (busy || res_strobe_o))
    else $error("fetch request lost");

  // The block only goes busy on an accepted request.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy without request");

endmodule

bind mean_pivot_contrast_stretch mpcs_checker u_mpcs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .req_i        (req_i),
  .res_o        (res_o),
  .res_strobe_o (res_strobe_o)
);
`default_nettype wire
